### rtl/core/obstacle_zone_hysteresis_top_macros.svh
// assertion macros shared by the obstacle zone checker
`ifndef OBSTACLE_ZONE_HYSTERESIS_TOP_MACROS_SVH
`define OBSTACLE_ZONE_HYSTERESIS_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define OZH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// property checked on every clock edge, reset included
`define OZH_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

### rtl/core/ozh_pkg.sv
// types, constants and register codes of the obstacle zone block
package ozh_pkg;

   localparam int DepthW   = 16;
   localparam int CountW   = 16;
   localparam int TimeW    = 32;
   localparam int SafeW    = 8;
   localparam int HoldW    = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int ReqDataW = 176;
   localparam int RspDataW = 8;

   localparam logic [SafeW-1:0] SafeMax = {SafeW{1'b1}};

   // reported zone codes, also used for the avoid state
   typedef enum logic [1:0] {
      ZONE_CLEAR  = 2'd0,
      ZONE_LEFT   = 2'd1,
      ZONE_RIGHT  = 2'd2,
      ZONE_CORNER = 2'd3
   } zone_type;

   // register indexes of the csr port
   typedef enum logic [CsrIdxW-1:0] {
      REG_ENTER_THR  = 3'd0,
      REG_EXIT_THR   = 3'd1,
      REG_EMERG_THR  = 3'd2,
      REG_NEAR_MIN   = 3'd3,
      REG_VALID_MIN  = 3'd4,
      REG_SAFE_NEED  = 3'd5,
      REG_HOLD_TIME  = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [DepthW-1:0] enter_thr;
      logic [DepthW-1:0] exit_thr;
      logic [DepthW-1:0] emerg_thr;
      logic [CountW-1:0] near_min;
      logic [CountW-1:0] valid_min;
      logic [SafeW-1:0]  safe_need;
      logic [HoldW-1:0]  hold_time;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      enter_thr: 16'd800,
      exit_thr:  16'd1000,
      emerg_thr: 16'd600,
      near_min:  16'd6,
      valid_min: 16'd20,
      safe_need: 8'd4,
      hold_time: 16'd300
   };

   // statistics of one zone
   typedef struct packed {
      logic [DepthW-1:0] depth;
      logic [CountW-1:0] near;
      logic [CountW-1:0] valid;
   } zone_stat_type;

   // obstacle flags of one zone at the three thresholds
   typedef struct packed {
      logic emerg;
      logic exit;
      logic enter;
   } zone_hit_type;

   // one registered input item
   typedef struct packed {
      zone_stat_type    left;
      zone_stat_type    front;
      zone_stat_type    right;
      logic [TimeW-1:0] frame_time;
   } frame_type;

endpackage

### rtl/core/ozh_cfg_regs.sv
// configuration register file written through the csr port
module ozh_cfg_regs
   import ozh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write, indexes past the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_ENTER_THR: cfg_in.enter_thr = csr_wdata;
            REG_EXIT_THR:  cfg_in.exit_thr  = csr_wdata;
            REG_EMERG_THR: cfg_in.emerg_thr = csr_wdata;
            REG_NEAR_MIN:  cfg_in.near_min  = csr_wdata;
            REG_VALID_MIN: cfg_in.valid_min = csr_wdata;
            REG_SAFE_NEED: cfg_in.safe_need = csr_wdata[SafeW-1:0];
            REG_HOLD_TIME: cfg_in.hold_time = csr_wdata[HoldW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/ozh_zone_eval.sv
// obstacle test of one zone against the three depth thresholds
module ozh_zone_eval
   import ozh_pkg::*;
(
   input  zone_stat_type stat,
   input  cfg_type       cfg,
   output zone_hit_type  hit
);

   logic trusted;

   // zone has data, enough valid samples and enough near samples
   assign trusted = (stat.depth != '0) && (stat.valid >= cfg.valid_min) &&
                    (stat.near >= cfg.near_min);

   // depth compares, each strict
   assign hit.emerg = trusted && (stat.depth < cfg.emerg_thr);
   assign hit.exit  = trusted && (stat.depth < cfg.exit_thr);
   assign hit.enter = trusted && (stat.depth < cfg.enter_thr);

endmodule

### rtl/core/ozh_decide.sv
// avoid state, safe frame count and hold logic, one frame per step
module ozh_decide
   import ozh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  cfg_type          cfg,
   input  zone_hit_type     left_hit,
   input  zone_hit_type     front_hit,
   input  zone_hit_type     right_hit,
   input  logic [TimeW-1:0] frame_time,
   output zone_type         zone
);

   zone_type         avoid_ff, avoid_in;
   logic [SafeW-1:0] safe_ff, safe_in;
   zone_type         held_ff, held_in;
   logic [TimeW-1:0] last_time_ff, last_time_in;

   zone_type         decision;
   logic             close_any;
   logic [SafeW-1:0] safe_inc;
   logic [SafeW-1:0] safe_need;
   logic [TimeW-1:0] age;

   assign close_any = left_hit.exit || front_hit.exit || right_hit.exit;
   assign safe_inc  = (safe_ff == SafeMax) ? safe_ff : safe_ff + 1'b1;
   // a needed count of zero acts as one
   assign safe_need = (cfg.safe_need == '0) ? SafeW'(1) : cfg.safe_need;
   assign age       = frame_time - last_time_ff;

   // zone decision and avoid state update
   always_comb begin
      avoid_in = avoid_ff;
      safe_in  = safe_ff;
      decision = ZONE_CLEAR;
      if (front_hit.emerg) begin
         avoid_in = ZONE_CORNER;
         safe_in  = '0;
         decision = ZONE_CORNER;
      end else if (avoid_ff != ZONE_CLEAR) begin
         decision = avoid_ff;
         if (close_any) begin
            safe_in = '0;
         end else if (safe_inc >= safe_need) begin
            avoid_in = ZONE_CLEAR;
            safe_in  = '0;
            decision = ZONE_CLEAR;
         end else begin
            safe_in = safe_inc;
         end
      end else if (front_hit.enter) begin
         avoid_in = ZONE_CORNER;
         safe_in  = '0;
         decision = ZONE_CORNER;
      end else if (left_hit.enter) begin
         avoid_in = ZONE_LEFT;
         safe_in  = '0;
         decision = ZONE_LEFT;
      end else if (right_hit.enter) begin
         avoid_in = ZONE_RIGHT;
         safe_in  = '0;
         decision = ZONE_RIGHT;
      end
   end

   // hold a non-clear zone for the hold time, wrapping age
   always_comb begin
      held_in      = held_ff;
      last_time_in = last_time_ff;
      zone         = decision;
      if (decision != ZONE_CLEAR) begin
         held_in      = decision;
         last_time_in = frame_time;
      end else if (age < {{(TimeW-HoldW){1'b0}}, cfg.hold_time}) begin
         zone = held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avoid_ff     <= ZONE_CLEAR;
         safe_ff      <= '0;
         held_ff      <= ZONE_CORNER;
         last_time_ff <= '0;
      end else if (step_en) begin
         avoid_ff     <= avoid_in;
         safe_ff      <= safe_in;
         held_ff      <= held_in;
         last_time_ff <= last_time_in;
      end
   end

endmodule

### rtl/core/obstacle_zone_hysteresis_top.sv
// top level of the obstacle zone hysteresis block
// One item per depth frame goes in and one zone code comes out for each.
// The block takes an item every cycle when the result side keeps up: an
// item is registered on accept, then the zone tests, avoid state update
// and hold check run in one pass and the code lands in the result
// register once it is free, where the receiver takes it. If the result
// waits, one more item is still taken into the input register before
// req_tready drops. Register writes take effect in the cycle after csr_we.
// They are to be made while no item is in flight; the block itself does
// not enforce this.
module obstacle_zone_hysteresis_top
   import ozh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // left depth, near, valid; front depth, near, valid; right depth, near,
   // valid (16 bits each), then frame_time_ms (32)
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   // zone_code (2), zeros above
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type      cfg;
   frame_type    frame_ff;
   logic         in_valid_ff, in_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   zone_type     rsp_zone_ff;
   zone_type     zone;
   logic         accept;
   logic         step;
   zone_hit_type left_hit, front_hit, right_hit;

   ozh_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake of the two register stages
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register, unpacked from the stream word
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff.left.depth  <= req_tdata[15:0];
         frame_ff.left.near   <= req_tdata[31:16];
         frame_ff.left.valid  <= req_tdata[47:32];
         frame_ff.front.depth <= req_tdata[63:48];
         frame_ff.front.near  <= req_tdata[79:64];
         frame_ff.front.valid <= req_tdata[95:80];
         frame_ff.right.depth <= req_tdata[111:96];
         frame_ff.right.near  <= req_tdata[127:112];
         frame_ff.right.valid <= req_tdata[143:128];
         frame_ff.frame_time  <= req_tdata[175:144];
      end
   end

   // zone obstacle tests
   ozh_zone_eval u_eval_left (
      .stat (frame_ff.left),
      .cfg  (cfg),
      .hit  (left_hit)
   );

   ozh_zone_eval u_eval_front (
      .stat (frame_ff.front),
      .cfg  (cfg),
      .hit  (front_hit)
   );

   ozh_zone_eval u_eval_right (
      .stat (frame_ff.right),
      .cfg  (cfg),
      .hit  (right_hit)
   );

   ozh_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step),
      .cfg        (cfg),
      .left_hit   (left_hit),
      .front_hit  (front_hit),
      .right_hit  (right_hit),
      .frame_time (frame_ff.frame_time),
      .zone       (zone)
   );

   // result register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_zone_ff <= zone;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW-2){1'b0}}, rsp_zone_ff};

endmodule

### rtl/core/ozh_checker.sv
// port-level checks of the obstacle zone block and their binding
`include "obstacle_zone_hysteresis_top_macros.svh"

module ozh_checker
   import ozh_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic [RspDataW-1:0] rsp_tdata,
   input logic                rsp_tvalid,
   input logic                rsp_tready
);

   // a stalled result holds its code
   `OZH_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // input side only stalls when both stages hold an item and the result waits
   `OZH_ASSERT(a_ready_backpressure, clock, reset, !req_tready |-> rsp_tvalid && !rsp_tready)

   // padding above the zone code stays zero
   `OZH_ASSERT(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_tdata[7:2] == 6'd0)

   // reset empties the pipeline
   `OZH_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind obstacle_zone_hysteresis_top ozh_checker u_ozh_checker (.*);

### test/tb.sv
// self-checking testbench of the obstacle zone hysteresis block
module tb;
   import ozh_pkg::*;

   localparam int StallLimit = 5000;
   localparam logic [10:0] RxPattern = 11'b111_0110_0111;

   typedef struct {
      zone_stat_type    left;
      zone_stat_type    front;
      zone_stat_type    right;
      logic [TimeW-1:0] stamp;
   } tb_frame_type;

   typedef enum int {RX_ALWAYS, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // predictor copy of the settings and the decision state
   cfg_type          cfg_now = CfgReset;
   zone_type         avoid_now = ZONE_CLEAR;
   logic [SafeW-1:0] safe_cnt = '0;
   zone_type         held_now = ZONE_CORNER;
   logic [TimeW-1:0] last_busy_ms = '0;

   zone_type         expected_zones[$];
   int               fail_count = 0;
   int               quiet_cycles = 0;
   logic [TimeW-1:0] now_ms = '0;
   rx_mode_type      ready_mode = RX_LIGHT;
   int               hold_off_req = 0;
   int               hold_off_left = 0;
   int               pat_phase = 0;

   obstacle_zone_hysteresis_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock, period 20
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] sat16(int v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
   endfunction

   function automatic zone_stat_type zn(logic [15:0] depth, logic [15:0] near,
                                        logic [15:0] valid);
      zone_stat_type z;
      z.depth = depth;
      z.near  = near;
      z.valid = valid;
      return z;
   endfunction

   function automatic tb_frame_type mk_frame(zone_stat_type l, zone_stat_type f,
                                             zone_stat_type r, logic [TimeW-1:0] stamp);
      tb_frame_type fr;
      fr.left  = l;
      fr.front = f;
      fr.right = r;
      fr.stamp = stamp;
      return fr;
   endfunction

   // left triple in the lowest bits, timestamp on top
   function automatic logic [ReqDataW-1:0] pack_frame(tb_frame_type f);
      return {f.stamp, f.right.valid, f.right.near, f.right.depth,
              f.front.valid, f.front.near, f.front.depth,
              f.left.valid, f.left.near, f.left.depth};
   endfunction

   function automatic tb_frame_type unpack_frame(logic [ReqDataW-1:0] d);
      return mk_frame(zn(d[15:0], d[31:16], d[47:32]),
                      zn(d[63:48], d[79:64], d[95:80]),
                      zn(d[111:96], d[127:112], d[143:128]),
                      d[175:144]);
   endfunction

   function automatic logic is_hit(zone_stat_type z, logic [DepthW-1:0] thr);
      return (z.depth != '0) && (z.valid >= cfg_now.valid_min) &&
             (z.depth < thr) && (z.near >= cfg_now.near_min);
   endfunction

   // zone decision with hysteresis and hold, updates the predictor state
   function automatic zone_type predict_zone(tb_frame_type f);
      zone_type         zone;
      logic [SafeW-1:0] need;
      logic [TimeW-1:0] age;
      logic             close;
      zone = ZONE_CLEAR;
      if (is_hit(f.front, cfg_now.emerg_thr)) begin
         avoid_now = ZONE_CORNER;
         safe_cnt  = '0;
         zone      = ZONE_CORNER;
      end else if (avoid_now != ZONE_CLEAR) begin
         close = is_hit(f.front, cfg_now.exit_thr) || is_hit(f.left, cfg_now.exit_thr) ||
                 is_hit(f.right, cfg_now.exit_thr);
         if (close) begin
            safe_cnt = '0;
            zone     = avoid_now;
         end else begin
            if (safe_cnt != SafeMax) safe_cnt = safe_cnt + 1'b1;
            need = (cfg_now.safe_need == '0) ? 8'd1 : cfg_now.safe_need;
            if (safe_cnt >= need) begin
               avoid_now = ZONE_CLEAR;
               safe_cnt  = '0;
               zone      = ZONE_CLEAR;
            end else begin
               zone = avoid_now;
            end
         end
      end else if (is_hit(f.front, cfg_now.enter_thr)) begin
         avoid_now = ZONE_CORNER;
         safe_cnt  = '0;
         zone      = ZONE_CORNER;
      end else if (is_hit(f.left, cfg_now.enter_thr)) begin
         avoid_now = ZONE_LEFT;
         safe_cnt  = '0;
         zone      = ZONE_LEFT;
      end else if (is_hit(f.right, cfg_now.enter_thr)) begin
         avoid_now = ZONE_RIGHT;
         safe_cnt  = '0;
         zone      = ZONE_RIGHT;
      end
      // hold the last non-clear zone for hold_time ms, wrapping age
      if (zone != ZONE_CLEAR) begin
         held_now     = zone;
         last_busy_ms = f.stamp;
      end else begin
         age = f.stamp - last_busy_ms;
         if (age < {16'd0, cfg_now.hold_time}) zone = held_now;
      end
      return zone;
   endfunction

   task automatic log_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // result check against the oldest expectation, then predict new items
   always @(posedge clock) begin : check_results
      zone_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_zones.size() == 0) begin
               log_fail($sformatf("unexpected result: zone %0d", rsp_tdata[1:0]));
            end else begin
               want = expected_zones.pop_front();
               if (rsp_tdata[1:0] !== want)
                  log_fail($sformatf("zone mismatch: expected %0d (%s) got %0d",
                                     want, want.name(), rsp_tdata[1:0]));
            end
         end
         if (req_tvalid && req_tready)
            expected_zones.insert(expected_zones.size(),
                                  predict_zone(unpack_frame(req_tdata)));
      end
   end

   // receiver stall pattern and long hold-off
   always @(posedge clock) begin
      if (hold_off_req != 0) begin
         hold_off_left = hold_off_req;
         hold_off_req  = 0;
      end
      pat_phase = (pat_phase + 1) % 11;
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_LIGHT:   rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_tready <= RxPattern[pat_phase];
            default:    rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_frame(tb_frame_type f);
      req_tdata  <= pack_frame(f);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected zone has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_zones.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CsrDataW-1:0] data, bit last);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_ENTER_THR: cfg_now.enter_thr = data;
         REG_EXIT_THR:  cfg_now.exit_thr  = data;
         REG_EMERG_THR: cfg_now.emerg_thr = data;
         REG_NEAR_MIN:  cfg_now.near_min  = data;
         REG_VALID_MIN: cfg_now.valid_min = data;
         REG_SAFE_NEED: cfg_now.safe_need = data[SafeW-1:0];
         REG_HOLD_TIME: cfg_now.hold_time = data;
         default: ;
      endcase
      if (last) begin
         csr_we <= 1'b0;
         repeat (2) @(posedge clock);
      end
   endtask

   task automatic apply_cfg(cfg_type c);
      write_reg(REG_ENTER_THR, c.enter_thr, 1'b0);
      write_reg(REG_EXIT_THR, c.exit_thr, 1'b0);
      write_reg(REG_EMERG_THR, c.emerg_thr, 1'b0);
      write_reg(REG_NEAR_MIN, c.near_min, 1'b0);
      write_reg(REG_VALID_MIN, c.valid_min, 1'b0);
      // upper byte of the safe frame register is unused
      write_reg(REG_SAFE_NEED, {8'($urandom_range(0, 255)), c.safe_need}, 1'b0);
      write_reg(REG_HOLD_TIME, c.hold_time, 1'b1);
   endtask

   // count around a minimum: mostly enough, sometimes short, sometimes anything
   function automatic logic [15:0] pick_count(logic [15:0] min_cnt);
      int r;
      r = $urandom_range(0, 9);
      if (r <= 6) return sat16(int'(min_cnt) + int'($urandom_range(0, 40)));
      if (r <= 8) return (min_cnt == 0) ? 16'd0 : 16'($urandom_range(0, min_cnt - 1));
      return 16'($urandom);
   endfunction

   function automatic zone_stat_type rand_zone(int clear_pct);
      zone_stat_type z;
      int            far;
      int            thr;
      int            r;
      far = int'(cfg_now.enter_thr);
      if (int'(cfg_now.exit_thr) > far) far = int'(cfg_now.exit_thr);
      if (int'(cfg_now.emerg_thr) > far) far = int'(cfg_now.emerg_thr);
      z.near  = pick_count(cfg_now.near_min);
      z.valid = pick_count(cfg_now.valid_min);
      // zone with no data or beyond every threshold
      if (int'($urandom_range(0, 99)) < clear_pct) begin
         z.depth = $urandom_range(0, 1) ? 16'd0 : sat16(far + int'($urandom_range(0, 3000)));
         return z;
      end
      r = $urandom_range(0, 9);
      case (r)
         0: z.depth = 16'd0;
         1, 2: begin
            case ($urandom_range(0, 2))
               0:       thr = int'(cfg_now.enter_thr);
               1:       thr = int'(cfg_now.exit_thr);
               default: thr = int'(cfg_now.emerg_thr);
            endcase
            z.depth = sat16(thr + int'($urandom_range(0, 2)) - 1);
         end
         3, 4, 5: z.depth = (far < 1) ? 16'd1 : 16'($urandom_range(1, far));
         6, 7:    z.depth = 16'($urandom);
         default: z.depth = 16'($urandom_range(1, 1500));
      endcase
      return z;
   endfunction

   // frame with random zones and a timestamp that mostly moves like a camera
   function automatic tb_frame_type rand_frame(int clear_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) now_ms = now_ms + $urandom_range(0, 60);
      else if (r < 95) now_ms = now_ms + $urandom_range(0, int'(cfg_now.hold_time) * 2 + 2);
      else now_ms = $urandom;
      return mk_frame(rand_zone(clear_pct), rand_zone(clear_pct), rand_zone(clear_pct),
                      now_ms);
   endfunction

   // reset values: clear frames early after reset still report corner
   task automatic test_reset_hold();
      send_frame(mk_frame(zn(0, 0, 0), zn(0, 0, 0), zn(0, 0, 0), 32'd0));
      send_frame(mk_frame(zn(16'hFFFF, 16'hFFFF, 16'hFFFF), zn(16'hFFFF, 16'hFFFF, 16'hFFFF),
                          zn(16'hFFFF, 16'hFFFF, 16'hFFFF), 32'd299));
      send_frame(mk_frame(zn(0, 16'hFFFF, 16'hFFFF), zn(0, 16'hFFFF, 16'hFFFF),
                          zn(0, 16'hFFFF, 16'hFFFF), 32'd300));
   endtask

   // zone order, emergency override and obstacle test edges
   task automatic test_zone_priority();
      cfg_type       c;
      zone_stat_type far_z;
      c = CfgReset;
      c.safe_need = 8'd1;
      c.hold_time = 16'd0;
      far_z = zn(16'd5000, 16'd100, 16'd100);
      wait_drain();
      apply_cfg(c);
      send_frame(mk_frame(far_z, zn(799, 6, 20), far_z, 32'd1000));
      send_frame(mk_frame(far_z, far_z, far_z, 32'd1010));
      send_frame(mk_frame(zn(1, 16'hFFFF, 16'hFFFF), far_z, zn(700, 50, 50), 32'd1020));
      send_frame(mk_frame(far_z, far_z, far_z, 32'd1030));
      send_frame(mk_frame(far_z, far_z, zn(799, 6, 20), 32'd1040));
      send_frame(mk_frame(far_z, zn(599, 6, 20), zn(700, 50, 50), 32'd1050));
      send_frame(mk_frame(far_z, far_z, far_z, 32'd1060));
      send_frame(mk_frame(zn(0, 16'hFFFF, 16'hFFFF), far_z, far_z, 32'd1070));
      send_frame(mk_frame(far_z, zn(500, 50, 19), far_z, 32'd1080));
      send_frame(mk_frame(far_z, far_z, zn(500, 5, 50), 32'd1090));
      send_frame(mk_frame(far_z, zn(800, 50, 50), far_z, 32'd1100));
   endtask

   // safe frame counting, threshold lowered mid-count, threshold zero
   task automatic test_safe_count();
      cfg_type       c;
      zone_stat_type far_z;
      c = CfgReset;
      c.hold_time = 16'd0;
      far_z = zn(16'hFFFF, 16'd100, 16'd100);
      wait_drain();
      apply_cfg(c);
      send_frame(mk_frame(zn(500, 10, 30), far_z, far_z, 32'd2000));
      send_frame(mk_frame(zn(999, 10, 30), far_z, far_z, 32'd2010));
      repeat (3) send_frame(mk_frame(far_z, far_z, far_z, 32'd2020));
      wait_drain();
      write_reg(REG_SAFE_NEED, 16'd2, 1'b1);
      send_frame(mk_frame(far_z, far_z, far_z, 32'd2030));
      wait_drain();
      write_reg(REG_SAFE_NEED, 16'd0, 1'b1);
      send_frame(mk_frame(far_z, zn(700, 10, 30), far_z, 32'd2040));
      send_frame(mk_frame(far_z, far_z, far_z, 32'd2050));
   endtask

   // hold age across the timestamp wrap
   task automatic test_hold_wrap();
      cfg_type       c;
      zone_stat_type far_z;
      c = CfgReset;
      c.safe_need = 8'd1;
      far_z = zn(16'd3000, 16'd100, 16'd100);
      wait_drain();
      apply_cfg(c);
      send_frame(mk_frame(far_z, zn(700, 10, 30), far_z, 32'hFFFF_FFFF));
      send_frame(mk_frame(far_z, far_z, far_z, 32'h0000_0100));
      send_frame(mk_frame(far_z, far_z, far_z, 32'h0000_012A));
      send_frame(mk_frame(far_z, far_z, far_z, 32'h0000_012B));
   endtask

   // long receiver hold-off fills the block, then random receiver stalls
   task automatic test_backpressure();
      wait_drain();
      apply_cfg(CfgReset);
      now_ms = 32'd5000;
      ready_mode   = RX_ALWAYS;
      hold_off_req = 300;
      repeat (24) send_frame(rand_frame(50));
      wait_drain();
      ready_mode = RX_HEAVY;
      repeat (24) send_frame(rand_frame(50));
      wait_drain();
   endtask

   function automatic cfg_type pick_cfg(int ph);
      cfg_type c;
      case (ph)
         0: c = CfgReset;
         1: c = '0;
         2: begin
            c = '1;
            c.safe_need = 8'hFF;
         end
         3: begin
            c.enter_thr = 16'($urandom);
            c.exit_thr  = 16'($urandom);
            c.emerg_thr = 16'($urandom);
            c.near_min  = 16'($urandom);
            c.valid_min = 16'($urandom);
            c.safe_need = 8'($urandom);
            c.hold_time = 16'($urandom);
         end
         default: begin
            c.enter_thr = 16'($urandom_range(200, 3000));
            c.exit_thr  = sat16(int'(c.enter_thr) + int'($urandom_range(0, 1000)));
            c.emerg_thr = 16'($urandom_range(0, c.enter_thr));
            c.near_min  = 16'($urandom_range(0, 40));
            c.valid_min = 16'($urandom_range(0, 100));
            c.safe_need = 8'($urandom_range(0, 12));
            c.hold_time = 16'($urandom_range(0, 600));
         end
      endcase
      return c;
   endfunction

   // random frames in bursts over several settings
   task automatic test_random();
      int sent;
      int burst;
      int clear_pct;
      for (int ph = 0; ph < 8; ph++) begin
         wait_drain();
         apply_cfg(pick_cfg(ph));
         ready_mode = rx_mode_type'($urandom_range(0, 3));
         sent = 0;
         while (sent < 145) begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
               0:       clear_pct = 20;
               1:       clear_pct = 60;
               default: clear_pct = 92;
            endcase
            repeat (burst) send_frame(rand_frame(clear_pct));
            sent += burst;
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_hold();
      test_zone_priority();
      test_safe_count();
      test_hold_wrap();
      test_backpressure();
      test_random();
      wait_drain();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ozh_pkg.sv
rtl/core/ozh_cfg_regs.sv
rtl/core/ozh_zone_eval.sv
rtl/core/ozh_decide.sv
rtl/core/obstacle_zone_hysteresis_top.sv
rtl/core/ozh_checker.sv
test/tb.sv
